### design/assert_macros.svh
// Assertion macros for the memory self-test block; clk and rst_n come from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define TMST_ASSERT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("memory self-test assertion failed");

// Property holds in the following cycle.
`define TMST_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("memory self-test assertion failed");

`endif

### design/tmst_pkg.sv
// Package: types, codes and constants of the memory self-test block.
`timescale 1ns / 1ps
`default_nettype none

package tmst_pkg;

    localparam int LENGTH_CAP_BYTES = 262144;
    localparam int LEN_W = $clog2(LENGTH_CAP_BYTES + 1);
    localparam int WC_W = LEN_W - 2;
    localparam int REGION_W = 25;
    localparam logic [REGION_W-1:0] REGION_MAX = 25'h100_0000;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_READ_DATA = 1'b1;

    // config register indexes
    localparam logic CFG_MEMORY_READY = 1'b0;
    localparam logic CFG_REGION_BYTES = 1'b1;

    // request kinds
    localparam logic [1:0] REQ_READ = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_DONE = 2'd2;

    // finish status
    localparam logic [1:0] ST_PASS = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_COMPARE_FAIL = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] base_offset;
        logic [31:0] length;
        logic [31:0] read_data;
    } tmst_in_t;

    typedef struct packed {
        logic [1:0]  request_kind;
        logic [21:0] word_offset;
        logic [31:0] write_data;
        logic [1:0]  status;
        logic [23:0] fail_byte_offset;
        logic [31:0] expected;
        logic [31:0] observed;
        logic [18:0] tested_bytes;
        logic        last;
    } tmst_out_t;

    // classified item between front and exec
    typedef struct packed {
        logic                is_read;
        logic                not_ready;
        logic                bad;
        logic [23:0]         off;
        logic [LEN_W-1:0]    len_c;
        logic [REGION_W-1:0] rem;
        logic [31:0]         read_data;
    } tmst_cmd_t;

    // up to two results per item, count in n
    typedef struct packed {
        logic [1:0] n;
        tmst_out_t  r0;
        tmst_out_t  r1;
    } tmst_res_push_t;

endpackage

`default_nettype wire

### design/tmst_front.sv
// Front: config registers and classification/clamping of incoming items.
`timescale 1ns / 1ps
`default_nettype none

module tmst_front
    import tmst_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tmst_in_t            item,
    input  wire logic                push,
    input  wire logic                full,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [REGION_W-1:0] cfg_data,
    output tmst_cmd_t                cmd,
    output logic                     cmd_push
);

    logic                ready_reg;
    logic [REGION_W-1:0] region_reg;
    logic [REGION_W-1:0] region;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg  <= 1'b0;
            region_reg <= 25'd2097152;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MEMORY_READY: ready_reg <= cfg_data[0];
                CFG_REGION_BYTES: region_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        region = (region_reg > REGION_MAX) ? REGION_MAX : region_reg;
        cmd.is_read   = (item.kind == KIND_READ_DATA);
        cmd.not_ready = !ready_reg;
        cmd.bad       = ({7'd0, region} <= item.base_offset)
                        || (item.base_offset[1:0] != 2'b00);
        cmd.off       = item.base_offset[23:0];
        // bytes left to the region end; meaningful only when not bad
        cmd.rem       = region - item.base_offset[REGION_W-1:0];
        cmd.len_c     = (item.length > 32'(LENGTH_CAP_BYTES))
                        ? LEN_W'(LENGTH_CAP_BYTES) : item.length[LEN_W-1:0];
        cmd.read_data = item.read_data;
    end

    assign cmd_push = push && !full;

endmodule

`default_nettype wire

### design/tmst_cmd_fifo.sv
// Two-entry queue of classified items between front and exec.
`timescale 1ns / 1ps
`default_nettype none

module tmst_cmd_fifo
    import tmst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire tmst_cmd_t wr_data,
    output logic           full,
    input  wire logic      rd,
    output tmst_cmd_t      rd_data,
    output logic           empty
);

    tmst_cmd_t  mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### design/tmst_exec.sv
// Exec: test sequencer that turns each item into up to two results: requests and/or a finish.
`timescale 1ns / 1ps
`default_nettype none

module tmst_exec
    import tmst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tmst_cmd_t cmd,
    input  wire logic      cmd_empty,
    output logic           cmd_pop,
    input  wire logic      res_space,
    output tmst_res_push_t res_push
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ORIG = 2'd1;
    localparam logic [1:0] PH_CHK1 = 2'd2;
    localparam logic [1:0] PH_CHK2 = 2'd3;

    logic [1:0]      phase_reg, phase_next;
    logic [WC_W-1:0] wi_reg, wi_next;
    logic [WC_W-1:0] wc_reg, wc_next;
    logic [21:0]     addr_reg, addr_next;
    logic [23:0]     fbo_reg, fbo_next;
    logic [31:0]     saved_reg, saved_next;

    logic [LEN_W-1:0] len_min;
    logic [WC_W-1:0]  wc_start;
    logic [WC_W-1:0]  wi_inc;
    logic [31:0]      pat;

    function automatic tmst_out_t mk_req(input logic [1:0] kind, input logic [21:0] woff,
                                         input logic [31:0] wdata);
        tmst_out_t r;
        r = '0;
        r.request_kind = kind;
        r.word_offset  = woff;
        r.write_data   = wdata;
        return r;
    endfunction

    function automatic tmst_out_t mk_done(input logic [1:0] st, input logic [23:0] fbo,
                                          input logic [31:0] expv, input logic [31:0] obs,
                                          input logic [18:0] tested);
        tmst_out_t r;
        r = '0;
        r.request_kind     = REQ_DONE;
        r.status           = st;
        r.fail_byte_offset = fbo;
        r.expected         = expv;
        r.observed         = obs;
        r.tested_bytes     = tested;
        r.last             = 1'b1;
        return r;
    endfunction

    assign cmd_pop = !cmd_empty && res_space;

    always_comb
    begin
        len_min  = ({{(REGION_W - LEN_W){1'b0}}, cmd.len_c} > cmd.rem)
                   ? cmd.rem[LEN_W-1:0] : cmd.len_c;
        wc_start = len_min[LEN_W-1:2];
        wi_inc   = wi_reg + 1'b1;
        pat      = {{(32 - WC_W){1'b0}}, wi_reg};

        phase_next = phase_reg;
        wi_next    = wi_reg;
        wc_next    = wc_reg;
        addr_next  = addr_reg;
        fbo_next   = fbo_reg;
        saved_next = saved_reg;
        res_push   = '0;

        if (cmd_pop)
        begin
            if (!cmd.is_read)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    res_push.n = 2'd1;
                    if (cmd.not_ready)
                    begin
                        res_push.r0 = mk_done(ST_NOT_READY, '0, '0, '0, '0);
                    end
                    else if (cmd.bad || (wc_start == '0))
                    begin
                        res_push.r0 = mk_done(ST_INVALID, '0, '0, '0, '0);
                    end
                    else
                    begin
                        res_push.r0 = mk_req(REQ_READ, cmd.off[23:2], '0);
                        phase_next  = PH_ORIG;
                        wi_next     = '0;
                        wc_next     = wc_start;
                        addr_next   = cmd.off[23:2];
                        fbo_next    = cmd.off;
                        saved_next  = '0;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        // stray read data: dropped
                    end
                    PH_ORIG:
                    begin
                        saved_next  = cmd.read_data;
                        res_push.n  = 2'd2;
                        res_push.r0 = mk_req(REQ_WRITE, addr_reg, pat);
                        res_push.r1 = mk_req(REQ_READ, addr_reg, '0);
                        phase_next  = PH_CHK1;
                    end
                    PH_CHK1:
                    begin
                        res_push.n = 2'd2;
                        if (cmd.read_data != pat)
                        begin
                            res_push.r0 = mk_req(REQ_WRITE, addr_reg, saved_reg);
                            res_push.r1 = mk_done(ST_COMPARE_FAIL, fbo_reg, pat,
                                                  cmd.read_data, '0);
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            res_push.r0 = mk_req(REQ_WRITE, addr_reg, ~pat);
                            res_push.r1 = mk_req(REQ_READ, addr_reg, '0);
                            phase_next  = PH_CHK2;
                        end
                    end
                    PH_CHK2:
                    begin
                        res_push.n  = 2'd2;
                        res_push.r0 = mk_req(REQ_WRITE, addr_reg, saved_reg);
                        if (cmd.read_data != ~pat)
                        begin
                            res_push.r1 = mk_done(ST_COMPARE_FAIL, fbo_reg, ~pat,
                                                  cmd.read_data, '0);
                            phase_next  = PH_IDLE;
                        end
                        else if (wi_inc != wc_reg)
                        begin
                            res_push.r1 = mk_req(REQ_READ, addr_reg + 22'd1, '0);
                            wi_next     = wi_inc;
                            addr_next   = addr_reg + 22'd1;
                            fbo_next    = fbo_reg + 24'd4;
                            phase_next  = PH_ORIG;
                        end
                        else
                        begin
                            res_push.r1 = mk_done(ST_PASS, '0, '0, '0, {wc_reg, 2'b00});
                            wi_next     = wi_inc;
                            phase_next  = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wi_reg    <= '0;
            wc_reg    <= '0;
            addr_reg  <= '0;
            fbo_reg   <= '0;
            saved_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            wi_reg    <= wi_next;
            wc_reg    <= wc_next;
            addr_reg  <= addr_next;
            fbo_reg   <= fbo_next;
            saved_reg <= saved_next;
        end
    end

endmodule

`default_nettype wire

### design/tmst_res_fifo.sv
// Four-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tmst_res_fifo
    import tmst_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tmst_res_push_t res_push,
    output logic                res_space,
    input  wire logic           pop,
    output logic                empty,
    output tmst_out_t           head
);

    tmst_out_t  mem_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic       rd;

    assign empty     = (cnt_reg == 3'd0);
    assign res_space = (cnt_reg <= 3'd2);
    assign head      = mem_reg[rp_reg];
    assign rd        = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (res_push.n != 2'd0)
        begin
            mem_reg[wp_reg] <= res_push.r0;
        end
        if (res_push.n == 2'd2)
        begin
            mem_reg[wp_reg + 2'd1] <= res_push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + res_push.n;
            rp_reg  <= rp_reg + {1'b0, rd};
            cnt_reg <= cnt_reg + {1'b0, res_push.n} - {2'b00, rd};
        end
    end

endmodule

`default_nettype wire

### design/transparent_memory_self_test.sv
// Top level of the transparent word-pattern memory self-test sequencer.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+----------------------------
//   input     | push / full               | item   (tmst_in_t)
//   result    | empty / pop               | result (tmst_out_t)
//   config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// An item enters the front each cycle that full is low; exec takes one queued item per
// cycle and pushes up to two results, and results leave at one per cycle while pop is high.
// Exec stalls when the result queue has fewer than two slots. An item is registered in the
// command queue, its results in the result queue. Reset clears queues and sequencer state,
// and sets memory_ready to 0 and region_bytes to 2097152.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module transparent_memory_self_test
    import tmst_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire tmst_in_t            item,
    output logic                     empty,
    input  wire logic                pop,
    output tmst_out_t                result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [REGION_W-1:0] cfg_data
);

    tmst_cmd_t      cmd_in;
    tmst_cmd_t      cmd_head;
    logic           cmd_push;
    logic           cmd_pop;
    logic           cmd_empty;
    logic           res_space;
    tmst_res_push_t res_push;

    tmst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_in),
        .cmd_push  (cmd_push)
    );

    tmst_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd      (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    tmst_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_space (res_space),
        .res_push  (res_push)
    );

    tmst_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_space (res_space),
        .pop       (pop),
        .empty     (empty),
        .head      (result)
    );

    `TMST_ASSERT(a_push_needs_item, res_push.n != 2'd0, cmd_pop)
    `TMST_ASSERT(a_last_is_done, !empty, result.last == (result.request_kind == REQ_DONE))
    `TMST_ASSERT(a_pop_needs_space, cmd_pop, res_space && !cmd_empty)
    `TMST_ASSERT_NEXT(a_accept_queued, push && !full, !cmd_empty)

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the transparent memory self-test sequencer.
`timescale 1ns / 1ps

module tb;
    import tmst_pkg::*;

    typedef enum logic [1:0] {RUN_IDLE, RUN_SAVE, RUN_PATTERN, RUN_INVERSE} run_phase_t;

    localparam int DRAIN_CYCLES = 8;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            push = 1'b0;
    logic            full;
    tmst_in_t        item = '0;
    logic            empty;
    logic            pop = 1'b0;
    tmst_out_t       result;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic            cfg_index = CFG_MEMORY_READY;
    logic [REGION_W-1:0] cfg_data = '0;

    transparent_memory_self_test dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // sequencer state as predicted from accepted items
    logic                mem_ready = 1'b0;
    logic [REGION_W-1:0] region_bytes = 25'd2097152;
    run_phase_t          run_phase = RUN_IDLE;
    logic [16:0]         word_index = '0;
    logic [21:0]         first_word = '0;
    logic [16:0]         word_count = '0;
    logic [31:0]         saved_word = '0;
    logic [23:0]         start_byte_offset = '0;

    tmst_out_t pending_requests[$];

    bit idle_en = 1'b1;
    int hold_request = 0;
    int hold_left = 0;
    int errors = 0;
    int useful_items = 0;
    int results_checked = 0;
    int register_writes = 0;
    int finish_tally[4] = '{0, 0, 0, 0};

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(3_000_000);
        $display("transparent_memory_self_test regression: fail");
        $finish;
    end

    function automatic logic [REGION_W-1:0] region_limit();
        return (region_bytes > REGION_MAX) ? REGION_MAX : region_bytes;
    endfunction

    function automatic void queue_request(logic [1:0] kind, logic [21:0] addr, logic [31:0] wdata);
        tmst_out_t r;
        r = '0;
        r.request_kind = kind;
        r.word_offset = addr;
        r.write_data = wdata;
        pending_requests.push_back(r);
    endfunction

    function automatic void queue_finish(logic [1:0] st, logic [23:0] fbo, logic [31:0] want,
                                         logic [31:0] got, logic [18:0] tested);
        tmst_out_t r;
        r = '0;
        r.request_kind = REQ_DONE;
        r.status = st;
        r.fail_byte_offset = fbo;
        r.expected = want;
        r.observed = got;
        r.tested_bytes = tested;
        r.last = 1'b1;
        pending_requests.push_back(r);
    endfunction

    // restore the word under test, then report the mismatch
    function automatic void abort_run(logic [21:0] addr, logic [31:0] want, logic [31:0] got);
        queue_request(REQ_WRITE, addr, saved_word);
        queue_finish(ST_COMPARE_FAIL, 24'(start_byte_offset + {word_index, 2'b00}), want, got,
                     '0);
        run_phase = RUN_IDLE;
    endfunction

    // returns the number of results the item causes
    function automatic int sequence_requests(tmst_in_t it);
        logic [33:0] off;
        logic [33:0] len;
        logic [33:0] region;
        logic [21:0] addr;
        logic [31:0] pattern;
        if (it.kind == KIND_START) begin
            if (run_phase != RUN_IDLE)
                return 0;
            if (!mem_ready) begin
                queue_finish(ST_NOT_READY, '0, '0, '0, '0);
                return 1;
            end
            off = 34'(it.base_offset);
            len = 34'(it.length);
            region = 34'(region_limit());
            if (len > 34'(LENGTH_CAP_BYTES))
                len = 34'(LENGTH_CAP_BYTES);
            if (off >= region || off[1:0] != 2'b00) begin
                queue_finish(ST_INVALID, '0, '0, '0, '0);
                return 1;
            end
            if (off + len > region)
                len = region - off;
            len[1:0] = 2'b00;
            if (len == '0) begin
                queue_finish(ST_INVALID, '0, '0, '0, '0);
                return 1;
            end
            start_byte_offset = off[23:0];
            first_word = off[23:2];
            word_count = len[18:2];
            word_index = '0;
            saved_word = '0;
            run_phase = RUN_SAVE;
            queue_request(REQ_READ, first_word, '0);
            return 1;
        end
        addr = 22'(first_word + word_index);
        pattern = 32'(word_index);
        case (run_phase)
            RUN_SAVE:
            begin
                saved_word = it.read_data;
                queue_request(REQ_WRITE, addr, pattern);
                queue_request(REQ_READ, addr, '0);
                run_phase = RUN_PATTERN;
                return 2;
            end
            RUN_PATTERN:
            begin
                if (it.read_data != pattern) begin
                    abort_run(addr, pattern, it.read_data);
                    return 2;
                end
                queue_request(REQ_WRITE, addr, ~pattern);
                queue_request(REQ_READ, addr, '0);
                run_phase = RUN_INVERSE;
                return 2;
            end
            RUN_INVERSE:
            begin
                if (it.read_data != ~pattern) begin
                    abort_run(addr, ~pattern, it.read_data);
                    return 2;
                end
                queue_request(REQ_WRITE, addr, saved_word);
                word_index = word_index + 17'd1;
                if (word_index < word_count) begin
                    queue_request(REQ_READ, 22'(first_word + word_index), '0);
                    run_phase = RUN_SAVE;
                end
                else begin
                    queue_finish(ST_PASS, '0, '0, '0, 19'({word_count, 2'b00}));
                    run_phase = RUN_IDLE;
                end
                return 2;
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic tmst_in_t start_command(logic [31:0] off, logic [31:0] len);
        tmst_in_t it;
        it.kind = KIND_START;
        it.base_offset = off;
        it.length = len;
        it.read_data = $urandom;
        return it;
    endfunction

    // what memory returns for the pending read, optionally corrupted
    function automatic tmst_in_t memory_reply(bit corrupt);
        tmst_in_t it;
        logic [31:0] good;
        it.kind = KIND_READ_DATA;
        it.base_offset = $urandom;
        it.length = $urandom;
        good = (run_phase == RUN_INVERSE) ? ~32'(word_index) : 32'(word_index);
        if (run_phase == RUN_SAVE || run_phase == RUN_IDLE)
            it.read_data = $urandom;
        else if (!corrupt)
            it.read_data = good;
        else if ($urandom_range(1) == 0)
            it.read_data = good ^ (32'd1 << $urandom_range(31));
        else
            it.read_data = good ^ ($urandom | 32'd1);
        return it;
    endfunction

    // push stays high on return so a following item goes out without a gap
    task automatic send_item(input tmst_in_t it);
        int n;
        while (idle_en && $urandom_range(99) < 24) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        n = sequence_requests(it);
        if (n > 0)
            useful_items++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_requests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [REGION_W-1:0] data);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MEMORY_READY)
            mem_ready = data[0];
        else
            region_bytes = data;
        register_writes++;
    endtask

    task automatic do_run(input logic [31:0] off, input logic [31:0] len,
                          input run_phase_t break_at, input int corrupt_pct,
                          input int stray_pct);
        send_item(start_command(off, len));
        while (run_phase != RUN_IDLE) begin
            if ($urandom_range(99) < stray_pct)
                send_item(start_command($urandom, $urandom));
            send_item(memory_reply(run_phase == break_at || $urandom_range(99) < corrupt_pct));
        end
    endtask

    task automatic random_run();
        logic [31:0] off;
        logic [31:0] len;
        logic [REGION_W-1:0] lim;
        int r;
        lim = region_limit();
        r = $urandom_range(99);
        len = 32'($urandom_range(1, 6) * 4 + $urandom_range(3));
        off = (lim >= 4) ? 32'({$urandom_range((lim >> 2) - 1), 2'b00}) : 32'd0;
        if (r < 8)
            off = $urandom;
        else if (r < 14)
            off = off + 32'($urandom_range(1, 3));
        else if (r < 22) begin
            len = $urandom;
            if (lim >= 16)
                off = 32'((lim >> 2) - $urandom_range(1, 4)) << 2;
        end
        else if (r < 26)
            len = 32'($urandom_range(3));
        else if (r < 30)
            off = 32'(lim);
        if ($urandom_range(9) == 0)
            send_item(memory_reply(1'b0));
        do_run(off, len, RUN_IDLE, 4, 8);
    endtask

    task automatic test_not_ready();
        send_item(start_command(32'd0, 32'hFFFF_FFFF));
        send_item(memory_reply(1'b0));
        send_item(start_command(32'hFFFF_FFFC, 32'd0));
    endtask

    task automatic test_start_checks();
        write_register(CFG_MEMORY_READY, 25'd1);
        send_item(start_command(32'd2097152, 32'd64));
        send_item(start_command(32'd2, 32'd64));
        send_item(start_command(32'hFFFF_FFFC, 32'hFFFF_FFFF));
        send_item(start_command(32'd0, 32'd0));
        send_item(start_command(32'd8, 32'd3));
        // length capped, then cut to the last word; starts during the run are dropped
        do_run(32'd2097148, 32'hFFFF_FFFF, RUN_IDLE, 0, 100);
    endtask

    task automatic test_compare_fail();
        do_run(32'd0, 32'd8, RUN_PATTERN, 0, 0);
        do_run(32'd16, 32'd12, RUN_INVERSE, 0, 0);
    endtask

    task automatic test_region_limits();
        write_register(CFG_REGION_BYTES, 25'd0);
        send_item(start_command(32'd0, 32'd4));
        write_register(CFG_REGION_BYTES, 25'h1FF_FFFF);
        do_run(32'd16777212, 32'hFFFF_FFFF, RUN_INVERSE, 0, 0);
        send_item(start_command(32'd16777216, 32'd4));
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        do_run(32'd0, 32'd96, RUN_IDLE, 0, 0);
        wait_drained();
        do_run(32'd4096, 32'd40, RUN_IDLE, 0, 0);
    endtask

    task automatic test_random();
        int target;
        int pass_no;
        logic [REGION_W-1:0] region;
        target = useful_items + 350;
        pass_no = 0;
        while (useful_items < target) begin
            case ($urandom_range(5))
                0: region = REGION_MAX;
                1: region = 25'h1FF_FFFF;
                2: region = 25'($urandom_range(1, 64));
                3: region = 25'($urandom_range(64, 65536));
                4: region = 25'($urandom);
                default: region = 25'd2097152;
            endcase
            write_register(CFG_REGION_BYTES, region);
            write_register(CFG_MEMORY_READY, 25'($urandom_range(9) != 0));
            idle_en = (pass_no != 2);
            repeat (12) random_run();
            pass_no++;
        end
        idle_en = 1'b1;
    endtask

    always @(posedge clk) begin
        if (!rst_n)
            pop <= 1'b0;
        else begin
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= !idle_en || ($urandom_range(99) >= 24);
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin
        tmst_out_t want;
        if (rst_n && pop && !empty) begin
            if (pending_requests.size() == 0) begin
                $error("result with nothing expected: %h", result);
                errors++;
            end
            else begin
                want = pending_requests.pop_front();
                compare_field("request_kind", 32'(want.request_kind), 32'(result.request_kind));
                compare_field("word_offset", 32'(want.word_offset), 32'(result.word_offset));
                compare_field("write_data", want.write_data, result.write_data);
                compare_field("status", 32'(want.status), 32'(result.status));
                compare_field("fail_byte_offset", 32'(want.fail_byte_offset),
                              32'(result.fail_byte_offset));
                compare_field("expected", want.expected, result.expected);
                compare_field("observed", want.observed, result.observed);
                compare_field("tested_bytes", 32'(want.tested_bytes), 32'(result.tested_bytes));
                compare_field("last", 32'(want.last), 32'(result.last));
                results_checked++;
                if (want.request_kind == REQ_DONE)
                    finish_tally[want.status]++;
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_not_ready();
        test_start_checks();
        test_compare_fail();
        test_region_limits();
        test_backpressure();
        test_random();
        wait_drained();
        $display("covered %0d items that caused results, %0d results, %0d register writes",
                 useful_items, results_checked, register_writes);
        $display("runs: %0d passed, %0d compare failures, %0d rejected, %0d not ready",
                 finish_tally[ST_PASS], finish_tally[ST_COMPARE_FAIL],
                 finish_tally[ST_INVALID], finish_tally[ST_NOT_READY]);
        if (errors == 0)
            $display("transparent_memory_self_test regression: pass");
        else
            $display("transparent_memory_self_test regression: fail");
        $finish;
    end

endmodule
